>>> design/rrf_pkg.sv
// Shared types and constants for the runoff routing filter.
// Used by rrf_cell, rrf_mul and runoff_routing_filter_core; depends on nothing.
`default_nettype none

package rrf_pkg;

  localparam int HIST_W = 32;
  localparam int TAP_W  = 17;
  localparam int FLOW_W = 48;

  localparam logic [FLOW_W-1:0] MAX48      = {FLOW_W{1'b1}};
  localparam logic [31:0]       ROUND_HALF = 32'h0000_8000;
  localparam logic [16:0]       ONE_Q16    = 17'h1_0000;

  // register indexes on the APB port (byte address = 4 * index)
  localparam logic [1:0] REG_INTERFLOW_RECESSION = 2'd0;
  localparam logic [1:0] REG_GROUND_RECESSION    = 2'd1;
  localparam logic [1:0] REG_DEPTH_TO_FLOW_GAIN  = 2'd2;
  localparam logic [1:0] REG_TAP_COUNT           = 2'd3;

  localparam logic KIND_TAP    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [3:0]        tap_index;
    logic [TAP_W-1:0]  tap_value;
    logic [HIST_W-1:0] surface_runoff;
    logic [HIST_W-1:0] interflow_runoff;
    logic [HIST_W-1:0] ground_runoff;
  } rrf_runoff_t;

  typedef struct packed {
    logic [FLOW_W-1:0] surface_flow;
    logic [FLOW_W-1:0] interflow_flow;
    logic [FLOW_W-1:0] ground_flow;
    logic [FLOW_W-1:0] total_flow;
  } rrf_flow_t;

  // broadcast control for the row of history/tap cells
  typedef struct packed {
    logic             shift;
    logic             rotate;
    logic [TAP_W-1:0] tap_data;
  } rrf_cell_ctl_t;

  function automatic logic [FLOW_W-1:0] sat_add48(input logic [FLOW_W-1:0] x,
                                                  input logic [FLOW_W-1:0] y);
    logic [FLOW_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[FLOW_W] ? MAX48 : s[FLOW_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/rrf_cell.sv
// One cell of the history/tap ring: a surface depth and a unit hydrograph tap.
// Depends on rrf_pkg for the cell control struct and widths.
`default_nettype none

module rrf_cell import rrf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rrf_cell_ctl_t     ctl,
  input  logic              tap_we,
  input  logic [HIST_W-1:0] hist_prev,
  input  logic [HIST_W-1:0] hist_next,
  input  logic [TAP_W-1:0]  tap_prev,
  output logic [HIST_W-1:0] hist,
  output logic [TAP_W-1:0]  tap
);

  // history shifts up on a new sample and rotates down during the convolution
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctl.shift) begin
      hist <= hist_prev;
    end else if (ctl.rotate) begin
      hist <= hist_next;
    end
  end

  // taps rotate up, opposite to the history, so pairs line up at fixed cells
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap <= ctl.tap_data;
    end else if (ctl.rotate) begin
      tap <= tap_prev;
    end
  end

endmodule

`default_nettype wire

>>> design/rrf_mul.sv
// 48 x 32 bit Q16 multiply with round half up and 48-bit saturation; products and result are registered.
// Depends on rrf_pkg for MAX48 and ROUND_HALF.
`default_nettype none

module rrf_mul import rrf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FLOW_W-1:0] a,
  input  logic [31:0]       b,
  output logic [FLOW_W-1:0] y,
  output logic              done
);

  logic [63:0] p_lo;
  logic [47:0] p_hi;
  logic        pend;
  logic [80:0] sum;

  always_ff @(posedge clk) begin
    if (start) begin
      p_lo <= a[31:0] * b;
      p_hi <= a[47:32] * b;
    end
  end

  assign sum = 81'({p_hi, 32'b0}) + 81'(p_lo) + 81'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (pend) begin
      y <= (|sum[80:64]) ? MAX48 : sum[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
    end
  end

endmodule

`default_nettype wire

>>> design/runoff_routing_filter_core.sv
// Runoff routing filter: unit hydrograph convolution plus two linear reservoirs.
// flow_valid rises in the same cycle that runoff_ready returns, so a new sample is taken
// only after the previous flow beat is issued; a stalled flow output holds the core busy.
// The tap ring takes MAX_TAPS rotations; the shared multiplier runs seven products (one
// on the first sample after reset). A tap write is taken while idle and gives no result.
// Reset (rst, synchronous) clears history and levels, returns registers to defaults; taps stay until written.
`default_nettype none

module runoff_routing_filter_core import rrf_pkg::*; #(
  parameter int MAX_TAPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        runoff_valid,
  output logic        runoff_ready,
  input  rrf_runoff_t runoff,
  output logic        flow_valid,
  input  logic        flow_ready,
  output rrf_flow_t   flow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W = 49 + $clog2(MAX_TAPS);
  localparam logic [IW-1:0] LAST_STEP = IW'(MAX_TAPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] OP_I_IN   = 3'd0;
  localparam logic [2:0] OP_I_KEEP = 3'd1;
  localparam logic [2:0] OP_I_ADD  = 3'd2;
  localparam logic [2:0] OP_G_IN   = 3'd3;
  localparam logic [2:0] OP_G_KEEP = 3'd4;
  localparam logic [2:0] OP_G_ADD  = 3'd5;
  localparam logic [2:0] OP_SURF   = 3'd6;

  // configuration registers
  logic [15:0] interflow_recession;
  logic [15:0] ground_recession;
  logic [31:0] depth_to_flow_gain;
  logic [4:0]  tap_count;

  logic [1:0]  state;
  logic        first_pending;
  logic        sample_accept;
  logic        tap_accept;

  // cell row
  rrf_cell_ctl_t     cell_ctl;
  logic [HIST_W-1:0] hist_q [MAX_TAPS];
  logic [TAP_W-1:0]  tap_q  [MAX_TAPS];

  // convolution
  logic              conv_run;
  logic              conv_tail;
  logic              conv_rnd;
  logic              conv_done;
  logic [IW-1:0]     step;
  logic [IW-1:0]     nm1;
  logic [TAP_W-1:0]  tap_sel;
  logic [48:0]       prod;
  logic              prod_v;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W:0]    acc_sum;
  logic [FLOW_W-1:0] acc_rnd;

  // reservoirs and shared multiplier
  logic [2:0]        op;
  logic              mul_busy;
  logic              mul_start;
  logic              mul_done;
  logic [FLOW_W-1:0] mul_a;
  logic [31:0]       mul_b;
  logic [FLOW_W-1:0] mul_y;
  logic [HIST_W-1:0] depth_i;
  logic [HIST_W-1:0] depth_g;
  logic [FLOW_W-1:0] level_i;
  logic [FLOW_W-1:0] level_g;
  logic [FLOW_W-1:0] inflow;
  logic [FLOW_W-1:0] kept;
  logic [FLOW_W-1:0] surf;
  logic [FLOW_W-1:0] total_part;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interflow_recession <= '0;
      ground_recession    <= '0;
      depth_to_flow_gain  <= 32'h0001_0000;
      tap_count           <= 5'd16;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_INTERFLOW_RECESSION: interflow_recession <= pwdata[15:0];
        REG_GROUND_RECESSION:    ground_recession    <= pwdata[15:0];
        REG_DEPTH_TO_FLOW_GAIN:  depth_to_flow_gain  <= pwdata;
        REG_TAP_COUNT:           tap_count           <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INTERFLOW_RECESSION: prdata = 32'(interflow_recession);
      REG_GROUND_RECESSION:    prdata = 32'(ground_recession);
      REG_DEPTH_TO_FLOW_GAIN:  prdata = depth_to_flow_gain;
      REG_TAP_COUNT:           prdata = 32'(tap_count);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- input beat ----------------
  assign runoff_ready  = (state == ST_IDLE);
  assign sample_accept = runoff_valid && runoff_ready && (runoff.kind == KIND_SAMPLE);
  assign tap_accept    = runoff_valid && runoff_ready && (runoff.kind == KIND_TAP);

  // ---------------- cell row ----------------
  assign cell_ctl.shift    = sample_accept;
  assign cell_ctl.rotate   = conv_run;
  assign cell_ctl.tap_data = runoff.tap_value;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic              tap_we;
    logic [HIST_W-1:0] hist_prev;

    assign tap_we    = tap_accept && (32'(runoff.tap_index) == 32'(k));
    assign hist_prev = (k == 0) ? runoff.surface_runoff : hist_q[(k + MAX_TAPS - 1) % MAX_TAPS];

    rrf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .tap_we    (tap_we),
      .hist_prev (hist_prev),
      .hist_next (hist_q[(k + 1) % MAX_TAPS]),
      .tap_prev  (tap_q[(k + MAX_TAPS - 1) % MAX_TAPS]),
      .hist      (hist_q[k]),
      .tap       (tap_q[k])
    );
  end

  // ---------------- convolution ----------------
  // clamp tap_count to 1..MAX_TAPS, kept as count minus one
  always_comb begin
    if (tap_count == 5'd0) begin
      nm1 = '0;
    end else if (32'(tap_count) > MAX_TAPS) begin
      nm1 = LAST_STEP;
    end else begin
      nm1 = IW'(tap_count - 5'd1);
    end
  end

  // after j rotations cell 0 holds history j and cell n-1 holds tap n-1-j
  assign tap_sel = tap_q[nm1];
  assign acc_sum = {1'b0, acc} + (ACC_W+1)'(ROUND_HALF);

  always_ff @(posedge clk) begin
    prod <= hist_q[0] * tap_sel;
    if (sample_accept) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (conv_rnd) begin
      acc_rnd <= FLOW_W'(acc_sum >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_run  <= 1'b0;
      conv_tail <= 1'b0;
      conv_rnd  <= 1'b0;
      conv_done <= 1'b0;
      step      <= '0;
      prod_v    <= 1'b0;
    end else begin
      prod_v    <= conv_run && (step <= nm1);
      conv_rnd  <= conv_tail;
      conv_tail <= 1'b0;
      if (sample_accept) begin
        conv_run  <= 1'b1;
        conv_done <= 1'b0;
        step      <= '0;
      end else if (conv_run) begin
        if (step == LAST_STEP) begin
          conv_run  <= 1'b0;
          conv_tail <= 1'b1;
          step      <= '0;
        end else begin
          step <= step + IW'(1);
        end
      end
      if (conv_rnd) begin
        conv_done <= 1'b1;
      end
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    case (op)
      OP_I_IN: begin
        mul_a = FLOW_W'(depth_i);
        mul_b = depth_to_flow_gain;
      end
      OP_I_KEEP: begin
        mul_a = level_i;
        mul_b = 32'(interflow_recession);
      end
      OP_I_ADD: begin
        mul_a = inflow;
        mul_b = 32'(ONE_Q16 - {1'b0, interflow_recession});
      end
      OP_G_IN: begin
        mul_a = FLOW_W'(depth_g);
        mul_b = depth_to_flow_gain;
      end
      OP_G_KEEP: begin
        mul_a = level_g;
        mul_b = 32'(ground_recession);
      end
      OP_G_ADD: begin
        mul_a = inflow;
        mul_b = 32'(ONE_Q16 - {1'b0, ground_recession});
      end
      OP_SURF: begin
        mul_a = acc_rnd;
        mul_b = depth_to_flow_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // surface product waits for the convolution to settle
  assign mul_start = (state == ST_BUSY) && !mul_busy && ((op != OP_SURF) || conv_done);

  rrf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .y     (mul_y),
    .done  (mul_done)
  );

  // ---------------- sequencer ----------------
  assign total_part = sat_add48(surf, level_i);

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      depth_i <= runoff.interflow_runoff;
      depth_g <= runoff.ground_runoff;
    end
    if (mul_done) begin
      case (op)
        OP_I_IN, OP_G_IN:     inflow <= mul_y;
        OP_I_KEEP, OP_G_KEEP: kept   <= mul_y;
        OP_SURF:              surf   <= mul_y;
        default: ;
      endcase
    end
    if ((state == ST_FIN) && (!flow_valid || flow_ready)) begin
      flow.surface_flow   <= surf;
      flow.interflow_flow <= level_i;
      flow.ground_flow    <= level_g;
      flow.total_flow     <= sat_add48(total_part, level_g);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_pending <= 1'b1;
      op            <= OP_I_IN;
      mul_busy      <= 1'b0;
      level_i       <= '0;
      level_g       <= '0;
      flow_valid    <= 1'b0;
    end else begin
      if (flow_valid && flow_ready) begin
        flow_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_accept) begin
            state         <= ST_BUSY;
            first_pending <= 1'b0;
            // the first sample after reset leaves both reservoirs empty
            if (first_pending) begin
              op      <= OP_SURF;
              level_i <= '0;
              level_g <= '0;
            end else begin
              op <= OP_I_IN;
            end
          end
        end
        ST_BUSY: begin
          if (mul_start) begin
            mul_busy <= 1'b1;
          end
          if (mul_done) begin
            mul_busy <= 1'b0;
            if (op == OP_I_ADD) begin
              level_i <= sat_add48(kept, mul_y);
            end
            if (op == OP_G_ADD) begin
              level_g <= sat_add48(kept, mul_y);
            end
            if (op == OP_SURF) begin
              state <= ST_FIN;
            end else begin
              op <= op + 3'd1;
            end
          end
        end
        ST_FIN: begin
          if (!flow_valid || flow_ready) begin
            flow_valid <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_mul_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy && !mul_done)
    else $error("multiplier started while a product is in flight");

  a_surf_after_conv: assert property (@(posedge clk) disable iff (rst)
    mul_start && (op == OP_SURF) |-> conv_done && !conv_run)
    else $error("surface product issued before convolution finished");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !conv_run && !mul_busy && (step == '0))
    else $error("work still in flight while idle");

  a_first_clears_on_sample: assert property (@(posedge clk) disable iff (rst)
    $fell(first_pending) |-> $past(sample_accept))
    else $error("first-sample flag cleared without a sample beat");

  a_ring_realigned: assert property (@(posedge clk) disable iff (rst)
    $rose(conv_done) |-> !conv_run && (step == '0))
    else $error("tap ring not back in place when convolution completes");

endmodule

`default_nettype wire

>>> tb/runoff_routing_filter_core_test.sv
// Self-checking testbench for runoff_routing_filter_core: surface convolution and reservoirs.
// Uses rrf_pkg for the beat structs, register indexes and constants; an internal
// predictor computes every expected flow beat.
module runoff_routing_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrf_pkg::*;

  localparam int TAPS          = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RANDOM_ITEMS  = 450;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        runoff_valid = 1'b0;
  logic        runoff_ready;
  rrf_runoff_t runoff = '0;
  logic        flow_valid;
  logic        flow_ready = 1'b0;
  rrf_flow_t   flow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b1;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  runoff_routing_filter_core #(.MAX_TAPS(TAPS)) dut (
    .clk(clk), .rst(rst),
    .runoff_valid(runoff_valid), .runoff_ready(runoff_ready), .runoff(runoff),
    .flow_valid(flow_valid), .flow_ready(flow_ready), .flow(flow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor state and register copies
  logic [31:0] hist [TAPS];
  logic [16:0] tap_mem [TAPS];
  logic [47:0] inter_level = '0;
  logic [47:0] ground_level = '0;
  bit          first_pending = 1'b1;
  logic [15:0] inter_rec_cfg = '0;
  logic [15:0] ground_rec_cfg = '0;
  logic [31:0] gain_cfg = 32'h0001_0000;
  logic [4:0]  tap_count_cfg = 5'd16;

  rrf_flow_t expected_flows [$];
  rrf_flow_t flow_want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int flows_checked = 0;
  int samples_sent = 0;
  int taps_sent = 0;
  int reg_writes = 0;

  initial begin
    for (int k = 0; k < TAPS; k++) hist[k] = '0;
  end

  // a * b >> 16, round half up, clip to 48 bits
  function automatic logic [47:0] scale_round(input logic [47:0] a, input logic [32:0] b);
    logic [80:0] p;
    p = {33'b0, a} * {48'b0, b} + 81'(ROUND_HALF);
    if (|p[80:64]) return MAX48;
    return p[63:16];
  endfunction

  function automatic logic [47:0] clip_add(input logic [47:0] x, input logic [47:0] y);
    logic [48:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [47:0] recede_level(input logic [47:0] level,
                                               input logic [15:0] c,
                                               input logic [31:0] depth);
    logic [47:0] inflow;
    logic [47:0] kept;
    logic [47:0] added;
    inflow = scale_round({16'b0, depth}, {1'b0, gain_cfg});
    kept = scale_round(level, {17'b0, c});
    added = scale_round(inflow, {16'b0, ONE_Q16} - {17'b0, c});
    return clip_add(kept, added);
  endfunction

  // update predictor state with one accepted beat; queue the flow it yields
  function automatic void route_runoff(input rrf_runoff_t item);
    int n;
    int j;
    logic [63:0] conv;
    rrf_flow_t res;
    if (item.kind == KIND_TAP) begin
      tap_mem[item.tap_index] = item.tap_value;
      return;
    end
    for (j = TAPS - 1; j > 0; j--) hist[j] = hist[j - 1];
    hist[0] = item.surface_runoff;
    n = tap_count_cfg;
    if (n < 1) n = 1;
    if (n > TAPS) n = TAPS;
    conv = '0;
    for (j = 0; j < n; j++) conv += {32'b0, hist[j]} * {47'b0, tap_mem[n - 1 - j]};
    conv = (conv + 64'(ROUND_HALF)) >> 16;
    res.surface_flow = scale_round(conv[47:0], {1'b0, gain_cfg});
    if (first_pending) begin
      // first sample after reset: reservoirs hold zero, depths dropped
      first_pending = 1'b0;
      inter_level = '0;
      ground_level = '0;
    end else begin
      inter_level = recede_level(inter_level, inter_rec_cfg, item.interflow_runoff);
      ground_level = recede_level(ground_level, ground_rec_cfg, item.ground_runoff);
    end
    res.interflow_flow = inter_level;
    res.ground_flow = ground_level;
    res.total_flow = clip_add(clip_add(res.surface_flow, inter_level), ground_level);
    expected_flows.push_back(res);
  endfunction

  function automatic logic [31:0] random_depth();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(0, 32'h0000_FFFF));
      3: return 32'($urandom_range(0, 32'h00FF_FFFF));
      default: return $urandom;
    endcase
  endfunction

  function automatic rrf_runoff_t random_runoff(input int tap_pct);
    rrf_runoff_t item;
    item.kind = ($urandom_range(99) < tap_pct) ? KIND_TAP : KIND_SAMPLE;
    item.tap_index = 4'($urandom_range(TAPS - 1));
    case ($urandom_range(7))
      0: item.tap_value = '0;
      1: item.tap_value = ONE_Q16;
      2: item.tap_value = '1;
      default: item.tap_value = 17'($urandom);
    endcase
    item.surface_runoff = random_depth();
    item.interflow_runoff = random_depth();
    item.ground_runoff = random_depth();
    return item;
  endfunction

  function automatic rrf_runoff_t make_sample(input logic [31:0] s, input logic [31:0] i,
                                              input logic [31:0] g);
    rrf_runoff_t item;
    item = '0;
    item.kind = KIND_SAMPLE;
    item.surface_runoff = s;
    item.interflow_runoff = i;
    item.ground_runoff = g;
    return item;
  endfunction

  // one input beat; valid is only lowered while idling
  task automatic offer_runoff(input rrf_runoff_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      runoff_valid <= 1'b0;
      @(posedge clk);
    end
    runoff <= item;
    runoff_valid <= 1'b1;
    @(posedge clk);
    while (!runoff_ready) @(posedge clk);
    route_runoff(item);
    if (item.kind == KIND_SAMPLE) samples_sent++;
    else taps_sent++;
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_INTERFLOW_RECESSION: inter_rec_cfg = value[15:0];
      REG_GROUND_RECESSION:    ground_rec_cfg = value[15:0];
      REG_DEPTH_TO_FLOW_GAIN:  gain_cfg = value;
      REG_TAP_COUNT:           tap_count_cfg = value[4:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic write_all_registers(input logic [31:0] ir, input logic [31:0] gr,
                                     input logic [31:0] gain, input logic [31:0] count);
    write_register(REG_INTERFLOW_RECESSION, ir);
    write_register(REG_GROUND_RECESSION, gr);
    write_register(REG_DEPTH_TO_FLOW_GAIN, gain);
    write_register(REG_TAP_COUNT, count);
  endtask

  // wait for every queued flow, then let a trailing tap write finish
  task automatic settle_block();
    runoff_valid <= 1'b0;
    while (expected_flows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_first_samples();
    rrf_runoff_t item;
    logic [16:0] v;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // every tap written before any sample reads one
    for (int k = 0; k < TAPS; k++) begin
      case (k)
        0: v = ONE_Q16;
        1: v = '0;
        2: v = '1;
        3: v = 17'd1;
        default: v = 17'(k * 3001);
      endcase
      item = random_runoff(0);
      item.kind = KIND_TAP;
      item.tap_index = 4'(k);
      item.tap_value = v;
      offer_runoff(item);
    end
    offer_runoff(make_sample('1, '1, '1));
    offer_runoff(make_sample('0, '0, '0));
    offer_runoff(make_sample('1, '1, '1));
    offer_runoff(make_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    offer_runoff(make_sample(32'd1, 32'd1, 32'd1));
    // tap rewrite with full depth fields: no flow beat, levels untouched
    item = make_sample('1, '1, '1);
    item.kind = KIND_TAP;
    item.tap_index = 4'd15;
    item.tap_value = 17'h1_2345;
    offer_runoff(item);
    offer_runoff(make_sample(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    settle_block();
  endtask

  task automatic test_register_extremes();
    logic [31:0] settings [6][4];
    settings = '{
      '{32'd0,     32'd0,     32'd0,         32'd1},
      '{32'd65535, 32'd65535, 32'hFFFF_FFFF, 32'd16},
      '{32'd0,     32'd65535, 32'hFFFF_FFFF, 32'd0},
      '{32'd65535, 32'd0,     32'h0001_0000, 32'd31},
      '{32'd32768, 32'd1,     32'h0001_8000, 32'd17},
      '{32'd1,     32'd65534, 32'h7FFF_FFFF, 32'd8}
    };
    for (int s = 0; s < 6; s++) begin
      write_all_registers(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
      offer_runoff(make_sample('1, '1, '1));
      for (int k = 0; k < 18; k++) offer_runoff(random_runoff(20));
      settle_block();
    end
  endtask

  task automatic test_random_runoff();
    int idle_table [4][2];
    logic [31:0] gain;
    logic [31:0] count;
    idle_table = '{'{0, 0}, '{88, 0}, '{0, 88}, '{21, 21}};
    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(4))
        0: gain = '0;
        1: gain = '1;
        2: gain = 32'h0001_0000;
        3: gain = 32'($urandom_range(0, 32'h000F_FFFF));
        default: gain = $urandom;
      endcase
      count = ($urandom_range(3) == 0) ? 32'($urandom_range(31)) : 32'($urandom_range(1, 16));
      write_all_registers(32'($urandom_range(16'hFFFF)), 32'($urandom_range(16'hFFFF)),
                          gain, count);
      send_idle_pct = idle_table[ph][0];
      recv_stall_pct = idle_table[ph][1];
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        // switch to steady pacing for one stretch inside each phase
        if (k == RANDOM_ITEMS / 2) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end else if (k == RANDOM_ITEMS / 2 + 40) begin
          send_idle_pct = idle_table[ph][0];
          recv_stall_pct = idle_table[ph][1];
        end
        offer_runoff(random_runoff(20));
      end
      settle_block();
    end
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int k = 0; k < 14; k++) offer_runoff(random_runoff(10));
    // sender waits for every flow beat before going on
    settle_block();
    offer_runoff(make_sample('1, '0, '1));
    settle_block();
  endtask

  // receiver pacing, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      flow_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      flow_ready <= 1'b0;
    end else begin
      flow_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void compare_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && flow_valid && flow_ready) begin
      if (expected_flows.size() == 0) begin
        mismatch_count++;
        $display("%0t: flow beat with none expected, expected nothing actual %h",
                 $time, flow);
      end else begin
        flow_want = expected_flows.pop_front();
        compare_field("surface_flow", flow_want.surface_flow, flow.surface_flow);
        compare_field("interflow_flow", flow_want.interflow_flow, flow.interflow_flow);
        compare_field("ground_flow", flow_want.ground_flow, flow.ground_flow);
        compare_field("total_flow", flow_want.total_flow, flow.total_flow);
        flows_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d flow beats outstanding", $time, expected_flows.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_samples();
    test_register_extremes();
    test_random_runoff();
    test_output_hold_off();
    settle_block();
    $display("Covered %0d runoff samples and %0d tap writes, %0d flow beats checked,",
             samples_sent, taps_sent, flows_checked);
    $display("%0d register writes incl. saturating gains, four pacing phases, %0d-cycle hold-off",
             reg_writes, HOLD_CYCLES);
    if (mismatch_count == 0 && expected_flows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
